/* rtl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants shared by the grid-square record parser.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned RegionMax = 9;

  typedef enum logic [2:0] {
    PH_COUNT     = 3'd0,
    PH_ST_COLOR  = 3'd1,
    PH_ST_TYPE   = 3'd2,
    PH_KB_COUNT  = 3'd3,
    PH_KN_COLOR  = 3'd4,
    PH_KN_BYTE   = 3'd5,
    PH_BD_COLOR  = 3'd6,
    PH_BD_REGION = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STITCH = 2'd1,
    KIND_KNOT   = 2'd2,
    KIND_BEAD   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_STITCH_CNT  = 3'd1,
    ERR_STITCH_TYPE = 3'd2,
    ERR_KNOT_CNT    = 3'd3,
    ERR_BEAD_CNT    = 3'd4,
    ERR_KNOT_BYTE   = 3'd5,
    ERR_BEAD_REGION = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    REG_STITCH_LIMIT = 3'd0,
    REG_KNOT_LIMIT   = 3'd1,
    REG_BEAD_LIMIT   = 3'd2,
    REG_STITCH_TYPES = 3'd3,
    REG_KNOT_TYPES   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] stitch_limit;
    logic [3:0] knot_limit;
    logic [3:0] bead_limit;
    logic [7:0] stitch_type_count;
    logic [4:0] knot_type_count;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] items_left;
    logic [6:0] item_slot;
    logic [7:0] held_color;
    logic [3:0] pending_beads;
  } parse_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] slot;
    logic [7:0] color;
    logic [7:0] type_code;
    logic [3:0] region;
    err_t       err;
    logic       done;
  } result_t;

endpackage

/* rtl/srp_cfg.sv */
// ----------------------------------------------------------------------------
// srp_cfg
// Configuration register file: limits and type counts for the parser.
// ----------------------------------------------------------------------------
module srp_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output srp_pkg::cfg_t cfg
);
  import srp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stitch_limit      <= 7'd16;
      cfg.knot_limit        <= 4'd15;
      cfg.bead_limit        <= 4'd15;
      cfg.stitch_type_count <= 8'd32;
      cfg.knot_type_count   <= 5'd4;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_STITCH_LIMIT: cfg.stitch_limit      <= cfg_data[6:0];
        REG_KNOT_LIMIT:   cfg.knot_limit        <= cfg_data[3:0];
        REG_BEAD_LIMIT:   cfg.bead_limit        <= cfg_data[3:0];
        REG_STITCH_TYPES: cfg.stitch_type_count <= cfg_data;
        REG_KNOT_TYPES:   cfg.knot_type_count   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/srp_step.sv */
// ----------------------------------------------------------------------------
// srp_step
// Single-byte parse step: next parser state and the result for one byte.
// ----------------------------------------------------------------------------
module srp_step (
  input  srp_pkg::cfg_t         cfg,
  input  srp_pkg::parse_state_t st,
  input  logic [7:0]            stream_byte,
  output srp_pkg::parse_state_t st_next,
  output srp_pkg::result_t      res
);
  import srp_pkg::*;

  logic [3:0] lo_nib;
  logic [3:0] hi_nib;
  logic [6:0] left_dec;
  logic [6:0] slot_inc;

  assign lo_nib   = stream_byte[3:0];
  assign hi_nib   = stream_byte[7:4];
  assign left_dec = st.items_left - 7'd1;
  assign slot_inc = st.item_slot + 7'd1;

  always_comb begin
    st_next = st;
    res     = '{kind: KIND_NONE, err: ERR_OK, default: '0};
    case (st.phase)
      PH_COUNT: begin
        if (stream_byte > {1'b0, cfg.stitch_limit}) begin
          res.err = ERR_STITCH_CNT;
        end else begin
          st_next.item_slot  = '0;
          st_next.items_left = stream_byte[6:0];
          st_next.phase      = (stream_byte[6:0] != '0) ? PH_ST_COLOR : PH_KB_COUNT;
        end
      end
      PH_ST_COLOR, PH_KN_COLOR, PH_BD_COLOR: begin
        st_next.held_color = stream_byte;
        st_next.phase      = phase_t'(st.phase + 3'd1);
      end
      PH_ST_TYPE: begin
        if (stream_byte >= cfg.stitch_type_count) begin
          res.err = ERR_STITCH_TYPE;
        end else begin
          st_next.item_slot  = slot_inc;
          st_next.items_left = left_dec;
          st_next.phase      = (left_dec != '0) ? PH_ST_COLOR : PH_KB_COUNT;
          res.kind      = KIND_STITCH;
          res.slot      = st.item_slot;
          res.color     = st.held_color;
          res.type_code = stream_byte;
        end
      end
      PH_KB_COUNT: begin
        if (lo_nib > cfg.knot_limit) begin
          res.err = ERR_KNOT_CNT;
        end else if (hi_nib > cfg.bead_limit) begin
          res.err = ERR_BEAD_CNT;
        end else begin
          st_next.pending_beads = hi_nib;
          st_next.item_slot     = '0;
          if (lo_nib != '0) begin
            st_next.items_left = {3'd0, lo_nib};
            st_next.phase      = PH_KN_COLOR;
          end else if (hi_nib != '0) begin
            st_next.items_left = {3'd0, hi_nib};
            st_next.phase      = PH_BD_COLOR;
          end else begin
            st_next.items_left = '0;
            st_next.phase      = PH_COUNT;
            res.done           = 1'b1;
          end
        end
      end
      PH_KN_BYTE: begin
        if (lo_nib > 4'(RegionMax) || {1'b0, hi_nib} >= cfg.knot_type_count) begin
          res.err = ERR_KNOT_BYTE;
        end else begin
          res.kind      = KIND_KNOT;
          res.slot      = st.item_slot;
          res.color     = st.held_color;
          res.type_code = {4'd0, hi_nib};
          res.region    = lo_nib;
          st_next.items_left = left_dec;
          st_next.item_slot  = slot_inc;
          if (left_dec != '0) begin
            st_next.phase = PH_KN_COLOR;
          end else if (st.pending_beads != '0) begin
            st_next.item_slot  = '0;
            st_next.items_left = {3'd0, st.pending_beads};
            st_next.phase      = PH_BD_COLOR;
          end else begin
            st_next.item_slot  = '0;
            st_next.items_left = '0;
            st_next.phase      = PH_COUNT;
            res.done           = 1'b1;
          end
        end
      end
      PH_BD_REGION: begin
        if (stream_byte > 8'(RegionMax)) begin
          res.err = ERR_BEAD_REGION;
        end else begin
          res.kind   = KIND_BEAD;
          res.slot   = st.item_slot;
          res.color  = st.held_color;
          res.region = lo_nib;
          st_next.items_left = left_dec;
          st_next.item_slot  = slot_inc;
          if (left_dec != '0) begin
            st_next.phase = PH_BD_COLOR;
          end else begin
            st_next.phase     = PH_COUNT;
            st_next.item_slot = '0;
            res.done          = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (res.err != ERR_OK) begin
      st_next.phase      = PH_COUNT;
      st_next.items_left = '0;
      st_next.item_slot  = '0;
      res.done           = 1'b1;
    end
  end

endmodule

/* rtl/square_record_parser.sv */
// ----------------------------------------------------------------------------
// square_record_parser
// Byte-stream parser for grid-square records with limit checks.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with stream_byte, one byte per transfer.
// Output channel: out_valid/out_ready with one result per input byte:
// element_kind, element_slot, color_index, type_code, region_code,
// error_code and record_done.
// Configuration: cfg_write/cfg_index/cfg_data, taken at any edge with
// cfg_write high; write only while the parser is idle.
// Path: an accepted byte is held in the input register and parsed from it;
// its result is then presented from the output register.
// Throughput: one byte per cycle while out_ready stays high; the parse step
// is combinational logic between the input register and the output register.
// Stall: when out_ready is low the result holds; one more byte may sit in
// the input register, after which in_ready drops until the result drains.
// Reset: rst clears the valid flags of both registers and returns the parser
// state (awaiting a stitch count) and the configuration to their defaults.
// ----------------------------------------------------------------------------
module square_record_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] element_kind,
  output logic [6:0] element_slot,
  output logic [7:0] color_index,
  output logic [7:0] type_code,
  output logic [3:0] region_code,
  output logic [2:0] error_code,
  output logic       record_done,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import srp_pkg::*;

  cfg_t         cfg;
  parse_state_t st;
  parse_state_t st_next;
  result_t      res_next;
  result_t      res;
  logic         byte_valid;
  logic [7:0]   byte_q;
  logic         advance;

  srp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srp_step u_step (
    .cfg         (cfg),
    .st          (st),
    .stream_byte (byte_q),
    .st_next     (st_next),
    .res         (res_next)
  );

  assign advance  = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_q <= stream_byte;
    end
  end

  // parser state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '{phase: PH_COUNT, default: '0};
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign element_kind = res.kind;
  assign element_slot = res.slot;
  assign color_index  = res.color;
  assign type_code    = res.type_code;
  assign region_code  = res.region;
  assign error_code   = res.err;
  assign record_done  = res.done;

  a_err_ends_record : assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |-> record_done && element_kind == KIND_NONE)
    else $error("error result without record end");

  a_err_resync : assert property (@(posedge clk) disable iff (rst)
    advance && res_next.err != ERR_OK |=> st.phase == PH_COUNT && st.items_left == '0)
    else $error("parser did not resync after error");

  a_empty_fields : assert property (@(posedge clk) disable iff (rst)
    out_valid && element_kind == KIND_NONE |->
      element_slot == '0 && color_index == '0 && type_code == '0 && region_code == '0)
    else $error("fields set with no element");

  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

/* tb/sv/tb_square_record_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_record_parser
// Self-checking bench for the grid-square record parser: a scoreboard
// tracks parse state and limits, predicts the result of every accepted byte
// and checks results in order. The stimulus is a short directed list, then
// mostly well-formed records with random content, mixed with corrupted and
// truncated records and raw noise. It runs under several register settings,
// including both extremes, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_square_record_parser;
  import srp_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainLimit = 1000;
  localparam int PhaseBytes = 240;
  localparam int RegSlots   = 2 ** $bits(reg_idx_t);

  class record_scoreboard;
    cfg_t       cfg;
    phase_t     phase;
    logic [6:0] items_left;
    logic [6:0] item_slot;
    logic [7:0] held_color;
    logic [3:0] pending_knots;
    logic [3:0] pending_beads;
    result_t    awaited[$];
    int         mismatches;
    int         results_seen;
    int         record_ends;
    int         kind_seen[4];
    int         err_seen[8];

    function new();
      cfg = '{stitch_limit: 7'd16, knot_limit: 4'd15, bead_limit: 4'd15,
              stitch_type_count: 8'd32, knot_type_count: 5'd4};
      phase = PH_COUNT;
      items_left = '0;
      item_slot = '0;
      held_color = '0;
      pending_knots = '0;
      pending_beads = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        REG_STITCH_LIMIT: cfg.stitch_limit = data[6:0];
        REG_KNOT_LIMIT:   cfg.knot_limit = data[3:0];
        REG_BEAD_LIMIT:   cfg.bead_limit = data[3:0];
        REG_STITCH_TYPES: cfg.stitch_type_count = data;
        REG_KNOT_TYPES:   cfg.knot_type_count = data[4:0];
        default: ;
      endcase
    endfunction

    function result_t abort_record(err_t code);
      result_t r;
      r = '0;
      phase = PH_COUNT;
      items_left = '0;
      item_slot = '0;
      r.err = code;
      r.done = 1'b1;
      return r;
    endfunction

    // advance to the bead list, or close the record when there are no beads
    function logic open_bead_list();
      item_slot = '0;
      if (pending_beads != 0) begin
        items_left = {3'b000, pending_beads};
        phase = PH_BD_COLOR;
        return 1'b0;
      end
      items_left = '0;
      phase = PH_COUNT;
      return 1'b1;
    endfunction

    function result_t parse_byte(logic [7:0] b);
      result_t r;
      r = '0;
      case (phase)
        PH_COUNT: begin
          if (b > cfg.stitch_limit) return abort_record(ERR_STITCH_CNT);
          item_slot = '0;
          items_left = b[6:0];
          phase = (items_left != 0) ? PH_ST_COLOR : PH_KB_COUNT;
        end
        PH_ST_COLOR, PH_KN_COLOR, PH_BD_COLOR: begin
          held_color = b;
          phase = phase_t'(phase + 1);
        end
        PH_ST_TYPE: begin
          if (b >= cfg.stitch_type_count) return abort_record(ERR_STITCH_TYPE);
          r.kind = KIND_STITCH;
          r.slot = item_slot;
          r.color = held_color;
          r.type_code = b;
          item_slot++;
          items_left--;
          phase = (items_left != 0) ? PH_ST_COLOR : PH_KB_COUNT;
        end
        PH_KB_COUNT: begin
          if (b[3:0] > cfg.knot_limit) return abort_record(ERR_KNOT_CNT);
          if (b[7:4] > cfg.bead_limit) return abort_record(ERR_BEAD_CNT);
          pending_knots = b[3:0];
          pending_beads = b[7:4];
          if (pending_knots != 0) begin
            item_slot = '0;
            items_left = {3'b000, pending_knots};
            phase = PH_KN_COLOR;
          end else begin
            r.done = open_bead_list();
          end
        end
        PH_KN_BYTE: begin
          if (b[3:0] > RegionMax || {1'b0, b[7:4]} >= cfg.knot_type_count)
            return abort_record(ERR_KNOT_BYTE);
          r.kind = KIND_KNOT;
          r.slot = item_slot;
          r.color = held_color;
          r.type_code = {4'b0000, b[7:4]};
          r.region = b[3:0];
          item_slot++;
          items_left--;
          if (items_left != 0) phase = PH_KN_COLOR;
          else r.done = open_bead_list();
        end
        default: begin
          if (b > RegionMax) return abort_record(ERR_BEAD_REGION);
          r.kind = KIND_BEAD;
          r.slot = item_slot;
          r.color = held_color;
          r.region = b[3:0];
          item_slot++;
          items_left--;
          if (items_left != 0) begin
            phase = PH_BD_COLOR;
          end else begin
            phase = PH_COUNT;
            item_slot = '0;
            r.done = 1'b1;
          end
        end
      endcase
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      awaited.push_back(parse_byte(b));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        $error("result with no byte awaiting it: kind %0d error %0d", got.kind, got.err);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("element_kind", want.kind, got.kind);
      compare_field("element_slot", want.slot, got.slot);
      compare_field("color_index", want.color, got.color);
      compare_field("type_code", want.type_code, got.type_code);
      compare_field("region_code", want.region, got.region);
      compare_field("error_code", want.err, got.err);
      compare_field("record_done", want.done, got.done);
      kind_seen[want.kind]++;
      err_seen[want.err]++;
      if (want.done && want.err == ERR_OK) record_ends++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] stream_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] element_kind;
  logic [6:0] element_slot;
  logic [7:0] color_index;
  logic [7:0] type_code;
  logic [3:0] region_code;
  logic [2:0] error_code;
  logic       record_done;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  record_scoreboard board;
  result_t          seen_result;
  bit               no_gaps;
  int               bytes_sent;
  int               settings_used;
  int               cycle_count;
  int               ready_hold;

  square_record_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .element_kind (element_kind),
    .element_slot (element_slot),
    .color_index  (color_index),
    .type_code    (type_code),
    .region_code  (region_code),
    .error_code   (error_code),
    .record_done  (record_done),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  assign seen_result = {element_kind, element_slot, color_index, type_code,
                        region_code, error_code, record_done};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      board.check_result(seen_result);
      ready_hold = no_gaps ? 0 : $urandom_range(0, 16);
      out_ready <= (ready_hold == 0);
    end else if (!out_ready) begin
      if (ready_hold > 0) ready_hold--;
      if (ready_hold == 0) out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.awaited.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (board.awaited.size() != 0) begin
      $error("%0d results never arrived", board.awaited.size());
      board.mismatches++;
      board.awaited.delete();
    end
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [7:0] stitch_lim, input logic [7:0] knot_lim,
                               input logic [7:0] bead_lim, input logic [7:0] stitch_types,
                               input logic [7:0] knot_types);
    for (int i = int'(REG_KNOT_TYPES) + 1; i < RegSlots; i++)
      program_reg(3'(i), 8'($urandom));
    program_reg(REG_STITCH_LIMIT, stitch_lim);
    program_reg(REG_KNOT_LIMIT, knot_lim);
    program_reg(REG_BEAD_LIMIT, bead_lim);
    program_reg(REG_STITCH_TYPES, stitch_types);
    program_reg(REG_KNOT_TYPES, knot_types);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // a code below count when one exists; with count zero any code (always rejected)
  function automatic logic [7:0] pick_code(int count, int top);
    if (count == 0) return 8'($urandom_range(0, top));
    return 8'($urandom_range(0, ((count < top + 1) ? count : top + 1) - 1));
  endfunction

  task automatic send_record();
    logic [7:0] bytes[$];
    logic [7:0] knot_type;
    int         shape;
    int         lim;
    int         n;
    int         knots;
    int         beads;
    shape = $urandom_range(0, 9);
    no_gaps = ($urandom_range(0, 3) == 0);
    if (shape == 0) begin
      repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom));
    end else begin
      lim = board.cfg.stitch_limit;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, lim)
                                       : $urandom_range(0, (lim < 4) ? lim : 4);
      knots = $urandom_range(0, board.cfg.knot_limit);
      beads = $urandom_range(0, board.cfg.bead_limit);
      bytes.push_back(8'(n));
      repeat (n) begin
        bytes.push_back(8'($urandom));
        bytes.push_back(pick_code(board.cfg.stitch_type_count, 255));
      end
      bytes.push_back({4'(beads), 4'(knots)});
      repeat (knots) begin
        knot_type = pick_code(board.cfg.knot_type_count, 15);
        bytes.push_back(8'($urandom));
        bytes.push_back({knot_type[3:0], 4'($urandom_range(0, RegionMax))});
      end
      repeat (beads) begin
        bytes.push_back(8'($urandom));
        bytes.push_back(8'($urandom_range(0, RegionMax)));
      end
      if (shape <= 2) begin
        if ($urandom_range(0, 1) == 0)
          bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom);
        else
          bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
      end
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  task automatic run_phase();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) send_record();
    drain();
  endtask

  initial begin
    logic [7:0] directed[$] = '{
      8'h01, 8'hff, 8'h1f, 8'h00,
      8'h80, 8'h11,
      8'h00, 8'h21, 8'h00, 8'h39, 8'haa, 8'h09, 8'h55, 8'h00,
      8'h01, 8'h12, 8'h20,
      8'h00, 8'h01, 8'h77, 8'h0a,
      8'h00, 8'h10, 8'h33, 8'h0a
    };
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i]);
    drain();
    run_phase();

    apply_setting(8'd127, 8'd15, 8'd15, 8'd255, 8'd16);
    run_phase();
    apply_setting(8'd0, 8'd0, 8'd0, 8'd1, 8'd1);
    run_phase();
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'd0, 8'd0);
    run_phase();
    apply_setting(8'hff, 8'($urandom), 8'($urandom), 8'($urandom), 8'hff);
    run_phase();
    repeat (2) begin
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
      run_phase();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d bytes under %0d register settings; %0d results, %0d records closed.",
             bytes_sent, settings_used + 1, board.results_seen, board.record_ends);
    $display("Stitches %0d, knots %0d, beads %0d; rejects %0d/%0d/%0d/%0d/%0d/%0d.",
             board.kind_seen[KIND_STITCH], board.kind_seen[KIND_KNOT],
             board.kind_seen[KIND_BEAD], board.err_seen[ERR_STITCH_CNT],
             board.err_seen[ERR_STITCH_TYPE], board.err_seen[ERR_KNOT_CNT],
             board.err_seen[ERR_BEAD_CNT], board.err_seen[ERR_KNOT_BYTE],
             board.err_seen[ERR_BEAD_REGION]);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/srp_pkg.sv
rtl/srp_cfg.sv
rtl/srp_step.sv
rtl/square_record_parser.sv
tb/sv/tb_square_record_parser.sv
